### rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants, codes and control types for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    // list geometry
    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // field widths
    localparam int CMD_W     = 2;
    localparam int POS_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int ECOUNT_W  = 7;

    // stream data widths, rounded up to whole bytes
    localparam int S_FIELDS_W = CMD_W + POS_W + VALUE_W;
    localparam int M_FIELDS_W = VALUE_W + STATUS_W + ECOUNT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 2'd0,
        CMD_REMOVE_POS = 2'd1,
        CMD_REMOVE_VAL = 2'd2,
        CMD_DUMP       = 2'd3
    } pls_command_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NULL     = 3'd4,
        ST_EMPTY    = 3'd5
    } pls_status_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the incoming transfer, rewind the dump index
        logic match;       // register the per-cell equality vector
        logic exec;        // apply the latched command and load its result
        logic dump_emit;   // load one dumped entry into the output register
    } pls_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        pls_command_t in_command;  // command field of the pending input transfer
        logic         list_empty;
        logic         dump_last;   // dump index points at the final entry
        logic         out_free;    // output register can take a result this cycle
    } pls_stat_t;

endpackage

### rtl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl
// Command sequencer: accepts a transfer, steps the datapath through match,
// execute or dump, and waits on the output register when it is occupied.
// ----------------------------------------------------------------------------
module pls_ctrl import pls_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pls_stat_t stat,
    output pls_ctrl_t ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.capture = 1'b1;
                    case (stat.in_command)
                        CMD_REMOVE_VAL: state_next = S_MATCH;
                        CMD_DUMP:       state_next = S_DUMP;
                        default:        state_next = S_EXEC;
                    endcase
                end
            end
            S_MATCH: begin
                ctrl.match = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    ctrl.exec  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (stat.out_free) begin
                    ctrl.dump_emit = 1'b1;
                    if (stat.list_empty || stat.dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/pls_dp.sv
// ----------------------------------------------------------------------------
// pls_dp
// List datapath: a row of entry cells that shift up or down in parallel,
// per-cell match compare, entry count, dump index and the output register.
// ----------------------------------------------------------------------------
module pls_dp import pls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    input  pls_ctrl_t            ctrl,
    output pls_stat_t            stat
);

    // latched input fields
    pls_command_t            cmd_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [VALUE_W-1:0]      val_reg;

    // list storage
    logic [VALUE_W-1:0]      entries_reg [DEPTH];
    logic [VALUE_W-1:0]      entries_next [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [DEPTH-1:0]        match_reg;
    logic [IDX_W-1:0]        idx_reg;

    // output register
    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic [VALUE_W-1:0]      m_value_reg;
    pls_status_t             m_status_reg;
    logic [ECOUNT_W-1:0]     m_count_reg;

    // execute stage signals
    pls_status_t             exec_status;
    logic [CNT_W-1:0]        ins_idx;
    logic [CNT_W-1:0]        del_idx;
    logic                    do_ins;
    logic                    do_del;
    logic                    found;
    logic [CNT_W-1:0]        match_idx;

    // status towards the controller
    assign stat.in_command = pls_command_t'(s_tdata[CMD_W-1:0]);
    assign stat.list_empty = (count_reg == '0);
    assign stat.dump_last  = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign stat.out_free   = !m_valid_reg || m_tready;

    // first matching cell
    always_comb begin
        found     = 1'b0;
        match_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                found     = 1'b1;
                match_idx = CNT_W'(i);
            end
        end
    end

    // decode the latched command
    always_comb begin
        exec_status = ST_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        del_idx     = '0;
        if (pos_reg > POS_W'(count_reg)) begin
            ins_idx = count_reg;
        end else begin
            ins_idx = CNT_W'(pos_reg);
        end
        case (cmd_reg)
            CMD_INSERT: begin
                if (val_reg == '0) begin
                    exec_status = ST_NULL;
                end else if (count_reg >= CNT_W'(DEPTH)) begin
                    exec_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_REMOVE_POS: begin
                if (pos_reg >= POS_W'(count_reg)) begin
                    exec_status = ST_BADPOS;
                end else begin
                    do_del  = 1'b1;
                    del_idx = CNT_W'(pos_reg);
                end
            end
            CMD_REMOVE_VAL: begin
                if (val_reg == '0) begin
                    exec_status = ST_NULL;
                end else if (!found) begin
                    exec_status = ST_NOTFOUND;
                end else begin
                    do_del  = 1'b1;
                    del_idx = match_idx;
                end
            end
            default: begin
                exec_status = ST_OK;
            end
        endcase
    end

    // per-cell next value: insert shifts up, delete shifts down
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entries_next[i] = entries_reg[i];
            if (do_ins) begin
                if (CNT_W'(i) == ins_idx) begin
                    entries_next[i] = val_reg;
                end else if (i > 0 && CNT_W'(i) > ins_idx) begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (do_del) begin
                if (i < DEPTH - 1 && CNT_W'(i) >= del_idx) begin
                    entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // input capture, match vector and cells
    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= pls_command_t'(s_tdata[CMD_W-1:0]);
            pos_reg <= s_tdata[CMD_W +: POS_W];
            val_reg <= s_tdata[CMD_W + POS_W +: VALUE_W];
        end
        if (ctrl.match) begin
            for (int i = 0; i < DEPTH; i++) begin
                match_reg[i] <= (entries_reg[i] == val_reg) && (CNT_W'(i) < count_reg);
            end
        end
        if (ctrl.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    // count and dump index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (ctrl.exec) begin
                count_reg <= count_next;
            end
            if (ctrl.capture) begin
                idx_reg <= '0;
            end else if (ctrl.dump_emit) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.exec || ctrl.dump_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            m_value_reg  <= '0;
            m_status_reg <= exec_status;
            m_count_reg  <= ECOUNT_W'(count_next);
            m_last_reg   <= 1'b1;
        end else if (ctrl.dump_emit) begin
            m_count_reg <= ECOUNT_W'(count_reg);
            if (stat.list_empty) begin
                m_value_reg  <= '0;
                m_status_reg <= ST_EMPTY;
                m_last_reg   <= 1'b1;
            end else begin
                m_value_reg  <= entries_reg[idx_reg];
                m_status_reg <= ST_OK;
                m_last_reg   <= stat.dump_last;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, m_count_reg, m_status_reg, m_value_reg};

endmodule

### rtl/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top
// Ordered list of 32-bit words with insert, remove at position, remove by
// value and dump commands.
// ----------------------------------------------------------------------------
//  channel   direction  fields (lowest bit first)
//  s_        in         tdata: command[1:0], position[8:2], item_value[40:9]
//  m_        out        tdata: out_value[31:0], status[34:32],
//                              entry_count[41:35]; tlast: last
//
//  insert and remove at position run capture then execute, remove by value
//  adds the registered per-cell compare between them; dump loads one entry
//  per cycle into the single output register while that register is free.
//  one command is in flight at a time; the sequencer holds off the next
//  transfer until the current command has loaded its final result.
//  m_tready low stalls the sequencer only when the output register is full.
//  reset clears the entry count; entry contents are left as they are.
// ----------------------------------------------------------------------------
module positional_list_store_top import pls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // command, position, item_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_value, status, entry_count
    output logic                 m_tlast
);

    pls_ctrl_t ctrl;
    pls_stat_t stat;

    // command sequencer
    pls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // list cells and output register
    pls_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .ctrl     (ctrl),
        .stat     (stat)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional list store. A mirror of the list,
// kept in a small class, predicts every reply from the commands that the
// block accepts, and checks each reply transfer field by field. The stimulus
// is a short directed opening, then random commands in phases that fill,
// drain and churn the list. Both sides of the stream pause at random.
// ----------------------------------------------------------------------------
module tb;
    import pls_pkg::*;

    // one reply of the list, as the bench expects it
    typedef struct {
        logic [VALUE_W-1:0]  value;
        pls_status_t         status;
        logic [ECOUNT_W-1:0] stored;
        logic                last;
    } list_reply_t;

    // mirror of the list contents and the replies still owed by the block
    class list_mirror;
        logic [VALUE_W-1:0] cells [DEPTH];
        int unsigned        n_stored;
        list_reply_t        reply_queue [$];
        int unsigned        errors;
        int unsigned        commands_seen;
        int unsigned        replies_seen;
        int unsigned        status_hits [6];
        int unsigned        cmd_hits [4];
        int unsigned        peak_fill;

        function new();
            n_stored = 0;
            errors = 0;
            commands_seen = 0;
            replies_seen = 0;
            peak_fill = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            foreach (cmd_hits[i]) cmd_hits[i] = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endfunction

        function void push_reply(logic [VALUE_W-1:0] value, pls_status_t st, logic last);
            list_reply_t r;
            r.value  = value;
            r.status = st;
            r.stored = ECOUNT_W'(n_stored);
            r.last   = last;
            reply_queue.push_back(r);
            status_hits[st]++;
        endfunction

        // close the gap left by the entry at idx
        function void drop_cell(int unsigned idx);
            for (int unsigned i = idx; i + 1 < n_stored; i++)
                cells[i] = cells[i + 1];
            n_stored--;
        endfunction

        // accepted command: update the mirror and queue its replies
        function void note_command(pls_command_t cmd, logic [POS_W-1:0] pos,
                                   logic [VALUE_W-1:0] val);
            pls_status_t st;
            int unsigned at;
            st = ST_OK;
            commands_seen++;
            cmd_hits[cmd]++;
            case (cmd)
                CMD_DUMP: begin
                    if (n_stored == 0)
                        push_reply('0, ST_EMPTY, 1'b1);
                    for (int unsigned i = 0; i < n_stored; i++)
                        push_reply(cells[i], ST_OK, i + 1 == n_stored);
                    return;
                end
                CMD_INSERT: begin
                    if (val == '0) begin
                        st = ST_NULL;
                    end else if (n_stored >= DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        at = (pos > n_stored) ? n_stored : pos;
                        for (int unsigned i = n_stored; i > at; i--)
                            cells[i] = cells[i - 1];
                        cells[at] = val;
                        n_stored++;
                        if (n_stored > peak_fill)
                            peak_fill = n_stored;
                    end
                end
                CMD_REMOVE_POS: begin
                    if (pos >= n_stored)
                        st = ST_BADPOS;
                    else
                        drop_cell(pos);
                end
                default: begin
                    if (val == '0) begin
                        st = ST_NULL;
                    end else begin
                        st = ST_NOTFOUND;
                        for (int unsigned i = 0; i < n_stored; i++) begin
                            if (cells[i] == val) begin
                                drop_cell(i);
                                st = ST_OK;
                                break;
                            end
                        end
                    end
                end
            endcase
            push_reply('0, st, 1'b1);
        endfunction

        // reply transfer seen on the master side
        function void check_reply(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] st,
                                  logic [ECOUNT_W-1:0] stored, logic last);
            list_reply_t e;
            replies_seen++;
            if (reply_queue.size() == 0) begin
                flag($sformatf("unexpected reply value %h status %0d count %0d last %0b",
                               value, st, stored, last));
                return;
            end
            e = reply_queue.pop_front();
            if (value !== e.value)
                flag($sformatf("reply %0d value: expected %h, got %h",
                               replies_seen, e.value, value));
            if (st !== e.status)
                flag($sformatf("reply %0d status: expected %0d, got %0d",
                               replies_seen, e.status, st));
            if (stored !== e.stored)
                flag($sformatf("reply %0d entry count: expected %0d, got %0d",
                               replies_seen, e.stored, stored));
            if (last !== e.last)
                flag($sformatf("reply %0d last: expected %0b, got %0b",
                               replies_seen, e.last, last));
        endfunction

        // anything still owed at the end is a failure
        function void close_out();
            if (reply_queue.size() != 0)
                flag($sformatf("%0d replies never arrived", reply_queue.size()));
            if (errors > 10)
                $display("%0d further errors not shown", errors - 10);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;    // command, position, item_value
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;    // out_value, status, entry_count
    logic                 m_tlast;

    bit         idle_on;
    list_mirror mirror;

    positional_list_store_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure in bursts
    initial begin
        int stall_left;
        logic ready_nxt;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                ready_nxt = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_nxt = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 5);
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = 1'b1;
            end
            m_tready <= ready_nxt;
        end
    end

    // reply monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            mirror.check_reply(m_tdata[31:0], m_tdata[34:32], m_tdata[41:35], m_tlast);
    end

    // one command transfer, with an optional gap before it
    task automatic send_cmd(pls_command_t cmd, logic [POS_W-1:0] pos,
                            logic [VALUE_W-1:0] val);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({val, pos, cmd});
        do @(posedge aclk); while (!s_tready);
        mirror.note_command(cmd, pos, val);
        @(negedge aclk);
    endtask

    // data word with a bias towards repeats and edge patterns
    function automatic logic [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r <= 5)
            return VALUE_W'($urandom_range(1, 6));
        if (r == 6)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    // a run of random commands with the given mix
    task automatic random_phase(int n_items, int w_ins, int w_rpos, int w_rval);
        pls_command_t       cmd;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        int                 r;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < w_ins)
                cmd = CMD_INSERT;
            else if (r < w_ins + w_rpos)
                cmd = CMD_REMOVE_POS;
            else if (r < w_ins + w_rpos + w_rval)
                cmd = CMD_REMOVE_VAL;
            else
                cmd = CMD_DUMP;
            // positions mostly near the fill level, sometimes anywhere
            r = $urandom_range(0, 9);
            if (r < 7)
                pos = POS_W'($urandom_range(0, mirror.n_stored + 1));
            else if (r < 9)
                pos = POS_W'($urandom_range(0, 127));
            else
                pos = $urandom_range(0, 1) ? 7'd127 : 7'd0;
            val = pick_word();
            // removal by value usually targets a word that is present
            if (cmd == CMD_REMOVE_VAL && mirror.n_stored > 0 && $urandom_range(0, 3) != 0)
                val = mirror.cells[$urandom_range(0, mirror.n_stored - 1)];
            send_cmd(cmd, pos, val);
        end
    endtask

    // stimulus and end of run
    initial begin
        mirror   = new();
        idle_on  = 1'b1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed opening: empty list, null words, ends of the fields
        send_cmd(CMD_DUMP,       7'd0,   32'h0);
        send_cmd(CMD_REMOVE_POS, 7'd0,   32'h0);
        send_cmd(CMD_REMOVE_VAL, 7'd0,   32'h0);
        send_cmd(CMD_REMOVE_VAL, 7'd3,   32'h1234_5678);
        send_cmd(CMD_INSERT,     7'd0,   32'h0);
        send_cmd(CMD_INSERT,     7'd127, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT,     7'd0,   32'h0000_0001);
        send_cmd(CMD_INSERT,     7'd1,   32'h8000_0000);
        send_cmd(CMD_INSERT,     7'd127, 32'h0000_0001);
        send_cmd(CMD_INSERT,     7'd2,   32'hA5A5_5A5A);
        send_cmd(CMD_DUMP,       7'd127, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE_VAL, 7'd0,   32'h0000_0001);
        send_cmd(CMD_REMOVE_VAL, 7'd0,   32'h7FFF_FFFF);
        send_cmd(CMD_REMOVE_POS, 7'd4,   32'h0);
        send_cmd(CMD_REMOVE_POS, 7'd127, 32'h0);
        send_cmd(CMD_REMOVE_POS, 7'd3,   32'h0);
        send_cmd(CMD_DUMP,       7'd0,   32'h0);
        send_cmd(CMD_REMOVE_POS, 7'd0,   32'h0);
        send_cmd(CMD_REMOVE_VAL, 7'd0,   32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE_POS, 7'd0,   32'h0);
        send_cmd(CMD_DUMP,       7'd0,   32'h0);

        // fill until full, drain, churn; the last stretch runs without pauses
        random_phase(70, 65, 10, 10);
        random_phase(60, 15, 40, 35);
        idle_on = 1'b0;
        random_phase(50, 40, 25, 20);
        idle_on = 1'b1;
        random_phase(40, 40, 25, 20);
        idle_on = 1'b0;
        random_phase(30, 40, 25, 20);
        s_tvalid <= 1'b0;

        while (mirror.reply_queue.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        mirror.close_out();

        $display("%0d commands (insert %0d, remove at position %0d, remove by value %0d, dump %0d)",
                 mirror.commands_seen, mirror.cmd_hits[CMD_INSERT],
                 mirror.cmd_hits[CMD_REMOVE_POS], mirror.cmd_hits[CMD_REMOVE_VAL],
                 mirror.cmd_hits[CMD_DUMP]);
        $display("%0d replies; peak fill %0d; full %0d, bad position %0d, not found %0d, null %0d, empty %0d",
                 mirror.replies_seen, mirror.peak_fill, mirror.status_hits[ST_FULL],
                 mirror.status_hits[ST_BADPOS], mirror.status_hits[ST_NOTFOUND],
                 mirror.status_hits[ST_NULL], mirror.status_hits[ST_EMPTY]);
        if (mirror.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
